// ===== rtl/ehgu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehgu_pkg: shared types and constants for the encoder health / unwrap block
// Register indexes, field widths, configuration defaults and the structs
// passed between the unwrap stage, the health tracker and the top level.
// ----------------------------------------------------------------------------
package ehgu_pkg;

	// single-turn resolution; the wrap is a plain modulo of the raw width
	localparam int COUNTS_PER_REV = 4096;
	localparam int RAW_W          = $clog2(COUNTS_PER_REV);
	localparam int POS_W          = 32;

	// configuration field widths
	localparam int OFFSET_W = 21;
	localparam int STEP_W   = 12;
	localparam int THR_W    = 4;
	localparam int BUS_W    = 8;
	localparam int CFG_W    = OFFSET_W;
	localparam int IDX_W    = 3;

	// streak counters
	localparam int                BAD_W   = 20;
	localparam logic [BAD_W-1:0]  BAD_CAP = BAD_W'(1000000);

	// register indexes
	localparam logic [IDX_W-1:0] REG_HALL_OFFSET      = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAX_STEP         = 3'd1;
	localparam logic [IDX_W-1:0] REG_BAD_TO_UNHEALTHY = 3'd2;
	localparam logic [IDX_W-1:0] REG_GOOD_TO_HEALTHY  = 3'd3;
	localparam logic [IDX_W-1:0] REG_BAD_TO_BUSCLEAR  = 3'd4;

	// reset values of the registers
	localparam logic [OFFSET_W-1:0] DEF_HALL_OFFSET      = '0;
	localparam logic [STEP_W-1:0]   DEF_MAX_STEP         = 12'd512;
	localparam logic [THR_W-1:0]    DEF_BAD_TO_UNHEALTHY = 4'd3;
	localparam logic [THR_W-1:0]    DEF_GOOD_TO_HEALTHY  = 4'd3;
	localparam logic [BUS_W-1:0]    DEF_BAD_TO_BUSCLEAR  = 8'd50;

	typedef struct packed {
		logic signed [OFFSET_W-1:0] hall_offset_counts;
		logic [STEP_W-1:0]          max_step;
		logic [THR_W-1:0]           bad_to_unhealthy;
		logic [THR_W-1:0]           good_to_healthy;
		logic [BUS_W-1:0]           bad_to_busclear;
	} cfg_t;

	typedef struct packed {
		logic             read_ok;
		logic [RAW_W-1:0] enc_angle;
		logic             hall_event;
	} item_t;

	typedef struct packed {
		logic feedback_ok;
		logic bus_recover;
	} health_t;

endpackage

// ===== rtl/ehgu_unwrap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehgu_unwrap: glitch gate and multi-turn position tracking
// Works out the shortest-path delta from the last accepted angle, rejects
// steps beyond max_step and keeps the zero-relative position up to date.
// ----------------------------------------------------------------------------
module ehgu_unwrap (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  ehgu_pkg::item_t                     item,
	input  ehgu_pkg::cfg_t                      cfg,
	output logic                                sample_ok,
	output logic signed [ehgu_pkg::POS_W-1:0]   pos_next
);

	logic [ehgu_pkg::RAW_W-1:0]        prev_raw_q;
	logic                              primed_q;
	logic signed [ehgu_pkg::POS_W-1:0] pos_q;

	logic signed [ehgu_pkg::RAW_W-1:0] delta;
	logic [ehgu_pkg::RAW_W:0]          mag;
	logic                              too_far;

	// wrapped difference read as two's complement is the shortest path
	assign delta   = $signed(item.enc_angle - prev_raw_q);
	assign mag     = delta[ehgu_pkg::RAW_W-1] ?
	                 (ehgu_pkg::RAW_W+1)'(-$signed({delta[ehgu_pkg::RAW_W-1], delta})) :
	                 {1'b0, delta};
	assign too_far = mag > {1'b0, cfg.max_step};

	assign sample_ok = item.read_ok && (!primed_q || !too_far);

	// position is count minus reference; a hall event pins it to the offset
	always_comb begin
		if (item.hall_event) begin
			pos_next = ehgu_pkg::POS_W'(cfg.hall_offset_counts);
		end else if (sample_ok && primed_q) begin
			pos_next = pos_q + ehgu_pkg::POS_W'(delta);
		end else begin
			pos_next = pos_q;
		end
	end

	// tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q <= '0;
			primed_q   <= 1'b0;
			pos_q      <= '0;
		end else if (advance) begin
			pos_q <= pos_next;
			if (sample_ok) begin
				prev_raw_q <= item.enc_angle;
				primed_q   <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ehgu_health.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehgu_health: good/bad streak counters and debounced feedback flag
// Counts runs of good and bad samples, sets or clears the health flag at the
// configured thresholds and raises a bus recovery pulse on one streak length.
// ----------------------------------------------------------------------------
module ehgu_health (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              sample_ok,
	input  ehgu_pkg::cfg_t    cfg,
	output ehgu_pkg::health_t health_next
);

	logic [ehgu_pkg::BAD_W-1:0] bad_q;
	logic [ehgu_pkg::THR_W-1:0] good_q;
	logic                       flag_q;

	logic [ehgu_pkg::BAD_W-1:0] bad_next;
	logic [ehgu_pkg::THR_W-1:0] good_next;
	logic                       flag_next;

	// streak updates and flag decision
	always_comb begin
		bad_next  = bad_q;
		good_next = good_q;
		flag_next = flag_q;
		health_next.bus_recover = 1'b0;
		if (sample_ok) begin
			bad_next = '0;
			if (good_q < cfg.good_to_healthy) begin
				good_next = good_q + 1'b1;
			end
			if (good_next >= cfg.good_to_healthy) begin
				flag_next = 1'b1;
			end
		end else begin
			good_next = '0;
			if (bad_q < ehgu_pkg::BAD_CAP) begin
				bad_next = bad_q + 1'b1;
			end
			if (bad_next >= ehgu_pkg::BAD_W'(cfg.bad_to_unhealthy)) begin
				flag_next = 1'b0;
			end
			health_next.bus_recover = (bad_next == ehgu_pkg::BAD_W'(cfg.bad_to_busclear));
		end
		health_next.feedback_ok = flag_next;
	end

	// streak state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q  <= '0;
			good_q <= '0;
			flag_q <= 1'b0;
		end else if (advance) begin
			bad_q  <= bad_next;
			good_q <= good_next;
			flag_q <= flag_next;
		end
	end

endmodule

// ===== rtl/encoder_health_glitch_unwrap_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_health_glitch_unwrap_top: encoder glitch gate, unwrap and health
// Takes one absolute encoder sample per request and returns one result with
// the debounced health flag, zero-relative position, recovery pulse and the
// gate decision.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   read_ok, enc_angle, hall_event
//   out      out_valid / out_ready feedback_ok, position, bus_recover,
//                                  sample_accepted
//   cfg      cfg_we                cfg_index, cfg_data
//
// One request per cycle sustained while out_ready is high; out_valid rises when
// the item moves from the input register into the result register.
// The state update is one pass of add, compare and streak logic between the
// input register and the result register.
// A stalled output holds its result while the input register still takes one
// more request; after reset all state and configuration take their defaults.
// ----------------------------------------------------------------------------
module encoder_health_glitch_unwrap_top (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// input requests
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic                                     read_ok,
	input  logic [ehgu_pkg::RAW_W-1:0]               enc_angle,
	input  logic                                     hall_event,
	// results
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic                                     feedback_ok,
	output logic signed [ehgu_pkg::POS_W-1:0]        position,
	output logic                                     bus_recover,
	output logic                                     sample_accepted,
	// configuration writes
	input  logic                                     cfg_we,
	input  logic [ehgu_pkg::IDX_W-1:0]               cfg_index,
	input  logic [ehgu_pkg::CFG_W-1:0]               cfg_data
);

	ehgu_pkg::cfg_t  cfg_q;
	ehgu_pkg::item_t item_s1;
	logic            valid_s1;

	logic                              valid_s2;
	logic                              feedback_ok_s2;
	logic signed [ehgu_pkg::POS_W-1:0] position_s2;
	logic                              bus_recover_s2;
	logic                              accepted_s2;

	logic                              advance;
	logic                              sample_ok;
	logic signed [ehgu_pkg::POS_W-1:0] pos_next;
	ehgu_pkg::health_t                 health_next;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hall_offset_counts <= ehgu_pkg::DEF_HALL_OFFSET;
			cfg_q.max_step           <= ehgu_pkg::DEF_MAX_STEP;
			cfg_q.bad_to_unhealthy   <= ehgu_pkg::DEF_BAD_TO_UNHEALTHY;
			cfg_q.good_to_healthy    <= ehgu_pkg::DEF_GOOD_TO_HEALTHY;
			cfg_q.bad_to_busclear    <= ehgu_pkg::DEF_BAD_TO_BUSCLEAR;
		end else if (cfg_we) begin
			case (cfg_index)
				ehgu_pkg::REG_HALL_OFFSET: begin
					cfg_q.hall_offset_counts <= cfg_data[ehgu_pkg::OFFSET_W-1:0];
				end
				ehgu_pkg::REG_MAX_STEP: begin
					cfg_q.max_step <= cfg_data[ehgu_pkg::STEP_W-1:0];
				end
				ehgu_pkg::REG_BAD_TO_UNHEALTHY: begin
					cfg_q.bad_to_unhealthy <= cfg_data[ehgu_pkg::THR_W-1:0];
				end
				ehgu_pkg::REG_GOOD_TO_HEALTHY: begin
					cfg_q.good_to_healthy <= cfg_data[ehgu_pkg::THR_W-1:0];
				end
				ehgu_pkg::REG_BAD_TO_BUSCLEAR: begin
					cfg_q.bad_to_busclear <= cfg_data[ehgu_pkg::BUS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// stage handshake: the input register moves on when the result slot frees
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.read_ok    <= read_ok;
			item_s1.enc_angle  <= enc_angle;
			item_s1.hall_event <= hall_event;
		end
	end

	// glitch gate and position tracking
	ehgu_unwrap u_unwrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item_s1),
		.cfg       (cfg_q),
		.sample_ok (sample_ok),
		.pos_next  (pos_next)
	);

	// streak counters and health flag
	ehgu_health u_health (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.sample_ok   (sample_ok),
		.cfg         (cfg_q),
		.health_next (health_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			feedback_ok_s2 <= health_next.feedback_ok;
			position_s2    <= pos_next;
			bus_recover_s2 <= health_next.bus_recover;
			accepted_s2    <= sample_ok;
		end
	end

	assign out_valid       = valid_s2;
	assign feedback_ok     = feedback_ok_s2;
	assign position        = position_s2;
	assign bus_recover     = bus_recover_s2;
	assign sample_accepted = accepted_s2;

`ifndef SYNTH
	// an empty result slot never holds back the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("in_ready low while result register empty");

	// recovery is only requested on a rejected sample
	a_recover_on_bad: assert property (@(posedge clk) disable iff (!arst_n)
		advance && health_next.bus_recover |-> !sample_ok)
		else $error("bus recovery raised on an accepted sample");

	// health can only come back on a sample that passed the gate
	a_health_rise_good: assert property (@(posedge clk) disable iff (!arst_n)
		advance && health_next.feedback_ok && !feedback_ok_s2 && valid_s2 |-> sample_ok)
		else $error("feedback_ok set by a rejected sample");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: encoder glitch gate, multi-turn unwrap and health tracker
// Sends encoder samples through the request channel and checks every result
// against a cycle-free model of the gate, unwrap, streak debounce, recovery
// pulse and hall zero capture. Directed corner cases come first, then
// random-walk phases under several register settings. Then come long bad
// streaks and a closing stretch with no idling on either side.
// ----------------------------------------------------------------------------
module testbench;

	// index with no register behind it; writes to it must change nothing
	localparam logic [ehgu_pkg::IDX_W-1:0] REG_SPARE = 3'd5;

	typedef struct packed {
		logic                       health;
		logic [ehgu_pkg::POS_W-1:0] pos;
		logic                       recover;
		logic                       used;
	} readout_t;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_ready;
	logic                              read_ok;
	logic [ehgu_pkg::RAW_W-1:0]        enc_angle;
	logic                              hall_event;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic                              feedback_ok;
	logic signed [ehgu_pkg::POS_W-1:0] position;
	logic                              bus_recover;
	logic                              sample_accepted;
	logic                              cfg_we;
	logic [ehgu_pkg::IDX_W-1:0]        cfg_index;
	logic [ehgu_pkg::CFG_W-1:0]        cfg_data;

	// model configuration and state
	ehgu_pkg::cfg_t model_cfg = '{ehgu_pkg::DEF_HALL_OFFSET, ehgu_pkg::DEF_MAX_STEP,
		ehgu_pkg::DEF_BAD_TO_UNHEALTHY, ehgu_pkg::DEF_GOOD_TO_HEALTHY,
		ehgu_pkg::DEF_BAD_TO_BUSCLEAR};
	logic [ehgu_pkg::RAW_W-1:0] last_angle = '0;
	logic                       armed      = 1'b0;
	logic [ehgu_pkg::POS_W-1:0] turns      = '0;
	logic [ehgu_pkg::POS_W-1:0] zero_ref   = '0;
	logic [ehgu_pkg::BAD_W-1:0] bad_run    = '0;
	logic [ehgu_pkg::THR_W-1:0] good_run   = '0;
	logic                       healthy    = 1'b0;

	readout_t pending_readouts[$];

	bit quiet = 1'b0;
	int stall_left = 0;
	int errors = 0;
	int items_sent = 0;
	int results_checked = 0;
	int used_seen = 0;
	int pulses_seen = 0;
	int reg_writes = 0;

	encoder_health_glitch_unwrap_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.read_ok(read_ok),
		.enc_angle(enc_angle),
		.hall_event(hall_event),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.feedback_ok(feedback_ok),
		.position(position),
		.bus_recover(bus_recover),
		.sample_accepted(sample_accepted),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// one tick of the gate, unwrap, streaks and zero capture
	function automatic readout_t advance_encoder_model(input logic ok_in,
			input logic [ehgu_pkg::RAW_W-1:0] raw, input logic hall);
		readout_t                   r;
		logic                       ok;
		logic                       recover;
		logic [ehgu_pkg::RAW_W-1:0] t;
		logic [ehgu_pkg::POS_W-1:0] off_ext;
		int                         d;
		ok = ok_in;
		recover = 1'b0;
		d = 0;
		if (ok && armed) begin
			t = raw - last_angle + ehgu_pkg::RAW_W'(ehgu_pkg::COUNTS_PER_REV / 2);
			d = int'(t) - ehgu_pkg::COUNTS_PER_REV / 2;
			if (d > int'(model_cfg.max_step) || d < -int'(model_cfg.max_step))
				ok = 1'b0;
		end
		if (ok) begin
			if (armed)
				turns = turns + ehgu_pkg::POS_W'(d);
			last_angle = raw;
			armed = 1'b1;
			bad_run = '0;
			if (good_run < model_cfg.good_to_healthy)
				good_run = good_run + 1'b1;
			if (good_run >= model_cfg.good_to_healthy)
				healthy = 1'b1;
		end else begin
			good_run = '0;
			if (bad_run < ehgu_pkg::BAD_CAP)
				bad_run = bad_run + 1'b1;
			if (bad_run >= ehgu_pkg::BAD_W'(model_cfg.bad_to_unhealthy))
				healthy = 1'b0;
			if (bad_run == ehgu_pkg::BAD_W'(model_cfg.bad_to_busclear))
				recover = 1'b1;
		end
		// zero capture happens after the sample update, primed or not
		if (hall) begin
			off_ext = {{(ehgu_pkg::POS_W - ehgu_pkg::OFFSET_W)
				{model_cfg.hall_offset_counts[ehgu_pkg::OFFSET_W-1]}},
				model_cfg.hall_offset_counts};
			zero_ref = turns - off_ext;
		end
		r.health = healthy;
		r.pos = turns - zero_ref;
		r.recover = recover;
		r.used = ok;
		return r;
	endfunction

	task automatic report_mismatch(input string field,
			input logic [ehgu_pkg::POS_W-1:0] got, input logic [ehgu_pkg::POS_W-1:0] want);
		errors++;
		$display("mismatch at result %0d: %s got %0h expected %0h",
			results_checked, field, got, want);
	endtask

	// result checker and request monitor
	always @(posedge clk) begin
		readout_t due;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_readouts.size() == 0) begin
					report_mismatch("result with nothing pending", position, '0);
				end else begin
					due = pending_readouts.pop_front();
					if (feedback_ok !== due.health)
						report_mismatch("feedback_ok", feedback_ok, due.health);
					if (position !== due.pos)
						report_mismatch("position", position, due.pos);
					if (bus_recover !== due.recover)
						report_mismatch("bus_recover", bus_recover, due.recover);
					if (sample_accepted !== due.used)
						report_mismatch("sample_accepted", sample_accepted, due.used);
				end
				results_checked++;
				if (sample_accepted === 1'b1)
					used_seen++;
				if (bus_recover === 1'b1)
					pulses_seen++;
			end
			if (in_valid && in_ready)
				pending_readouts.push_back(advance_encoder_model(read_ok, enc_angle,
					hall_event));
		end
	end

	// receiver stalls in random bursts
	always @(negedge clk) begin
		logic nxt;
		if (stall_left > 0) begin
			stall_left--;
			nxt = 1'b0;
		end else if (!quiet && $urandom_range(0, 6) == 0) begin
			stall_left = $urandom_range(1, 9) - 1;
			nxt = 1'b0;
		end else begin
			nxt = 1'b1;
		end
		out_ready <= nxt;
	end

	// one request; starts and ends just after a falling edge
	task automatic send_sample(input logic ok, input logic [ehgu_pkg::RAW_W-1:0] raw,
			input logic hall);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		read_ok <= ok;
		enc_angle <= raw;
		hall_event <= hall;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
	endtask

	// hold off requests until every result is back
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_readouts.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input logic [ehgu_pkg::IDX_W-1:0] idx,
			input logic [ehgu_pkg::CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			ehgu_pkg::REG_HALL_OFFSET:
				model_cfg.hall_offset_counts = value[ehgu_pkg::OFFSET_W-1:0];
			ehgu_pkg::REG_MAX_STEP:
				model_cfg.max_step = value[ehgu_pkg::STEP_W-1:0];
			ehgu_pkg::REG_BAD_TO_UNHEALTHY:
				model_cfg.bad_to_unhealthy = value[ehgu_pkg::THR_W-1:0];
			ehgu_pkg::REG_GOOD_TO_HEALTHY:
				model_cfg.good_to_healthy = value[ehgu_pkg::THR_W-1:0];
			ehgu_pkg::REG_BAD_TO_BUSCLEAR:
				model_cfg.bad_to_busclear = value[ehgu_pkg::BUS_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_block(input logic [ehgu_pkg::OFFSET_W-1:0] off, input int step,
			input int bad, input int good, input int bus);
		settle();
		write_register(ehgu_pkg::REG_HALL_OFFSET, off);
		write_register(ehgu_pkg::REG_MAX_STEP, ehgu_pkg::CFG_W'(step));
		write_register(ehgu_pkg::REG_BAD_TO_UNHEALTHY, ehgu_pkg::CFG_W'(bad));
		write_register(ehgu_pkg::REG_GOOD_TO_HEALTHY, ehgu_pkg::CFG_W'(good));
		write_register(ehgu_pkg::REG_BAD_TO_BUSCLEAR, ehgu_pkg::CFG_W'(bus));
	endtask

	// mostly believable motion, some failed reads and wild jumps
	task automatic random_sample(input int fail_pct, input int jump_pct, input int hall_pct);
		int                         roll;
		int                         span;
		int                         s;
		logic                       ok;
		logic [ehgu_pkg::RAW_W-1:0] raw;
		roll = $urandom_range(0, 99);
		span = int'(model_cfg.max_step);
		ok = 1'b1;
		if (roll < fail_pct) begin
			ok = 1'b0;
			raw = ehgu_pkg::RAW_W'($urandom);
		end else if (roll < fail_pct + jump_pct) begin
			raw = ehgu_pkg::RAW_W'($urandom);
		end else begin
			// now and then sit right on the gate boundary
			if ($urandom_range(0, 9) == 0)
				s = span + int'($urandom_range(0, 1));
			else
				s = int'($urandom_range(0, span));
			if ($urandom_range(0, 1) == 1)
				s = -s;
			raw = last_angle + ehgu_pkg::RAW_W'(s);
		end
		send_sample(ok, raw, $urandom_range(0, 99) < hall_pct);
	endtask

	// failed reads mixed with half-turn jumps the gate must refuse
	task automatic bad_burst(input int len);
		repeat (len) begin
			if (armed && model_cfg.max_step < ehgu_pkg::STEP_W'(2048) &&
					$urandom_range(0, 3) == 0)
				send_sample(1'b1, last_angle + ehgu_pkg::RAW_W'(2048),
					$urandom_range(0, 9) == 0);
			else
				send_sample(1'b0, ehgu_pkg::RAW_W'($urandom), $urandom_range(0, 9) == 0);
		end
	endtask

	// priming, gate limits either side, wrap crossing and health debounce
	task automatic test_gate_edges();
		send_sample(1'b0, 12'hABC, 1'b0);
		send_sample(1'b1, 12'hFFF, 1'b0);
		send_sample(1'b1, 12'h1FF, 1'b0);
		send_sample(1'b1, 12'h000, 1'b0);
		send_sample(1'b1, 12'hDFF, 1'b0);
		send_sample(1'b1, 12'hE00, 1'b0);
		send_sample(1'b1, 12'h001, 1'b1);
		send_sample(1'b0, 12'h000, 1'b0);
		send_sample(1'b0, 12'hFFF, 1'b1);
		send_sample(1'b1, 12'hE80, 1'b0);
	endtask

	// offset extremes on hall capture, widest and narrowest gate
	task automatic test_hall_and_step_extremes();
		program_block(21'h100000, 2048, 3, 3, 50);
		send_sample(1'b1, last_angle + 12'd2048, 1'b1);
		send_sample(1'b1, last_angle + 12'd2047, 1'b0);
		program_block(21'h0FFFFF, 0, 3, 3, 50);
		send_sample(1'b1, last_angle, 1'b1);
		send_sample(1'b1, last_angle + 12'd1, 1'b0);
		send_sample(1'b1, last_angle + 12'hFFF, 1'b0);
	endtask

	// zero thresholds, over-wide writes and the spare index
	task automatic test_threshold_corners();
		settle();
		write_register(ehgu_pkg::REG_BAD_TO_UNHEALTHY, '0);
		write_register(ehgu_pkg::REG_GOOD_TO_HEALTHY, '0);
		write_register(ehgu_pkg::REG_BAD_TO_BUSCLEAR, 21'd1);
		write_register(ehgu_pkg::REG_MAX_STEP, 21'h1FF200);
		send_sample(1'b0, 12'h5A5, 1'b0);
		send_sample(1'b1, last_angle, 1'b0);
		send_sample(1'b0, 12'h000, 1'b0);
		settle();
		write_register(ehgu_pkg::REG_BAD_TO_BUSCLEAR, 21'h1FFF00);
		write_register(ehgu_pkg::REG_GOOD_TO_HEALTHY, 21'h0FFF1);
		write_register(REG_SPARE, 21'h1FFFFF);
		write_register(ehgu_pkg::REG_BAD_TO_UNHEALTHY, 21'h1FFF2);
		send_sample(1'b0, 12'hFFF, 1'b1);
		send_sample(1'b0, 12'h800, 1'b0);
		send_sample(1'b1, last_angle, 1'b0);
	endtask

	// random walks under fixed and random settings
	task automatic test_tracking_walk();
		program_block(21'($urandom), 512, 3, 3, 50);
		repeat (150) random_sample(8, 6, 5);
		program_block(21'h0FFFFF, 2048, 15, 15, 255);
		repeat (150) random_sample(6, 6, 5);
		program_block(21'h100000, 1, 1, 1, 1);
		repeat (150) random_sample(8, 4, 8);
		program_block(21'($urandom), $urandom_range(0, 2048), $urandom_range(1, 15),
			$urandom_range(1, 15), $urandom_range(1, 40));
		repeat (150) random_sample(10, 6, 5);
	endtask

	// long bad streaks reaching the recovery threshold
	task automatic test_streaks_and_recovery();
		program_block(21'($urandom), 300, 4, 5, 255);
		bad_burst(256);
		program_block(21'($urandom), 512, $urandom_range(1, 15), $urandom_range(1, 15), 20);
		repeat (8) begin
			repeat ($urandom_range(1, 15)) random_sample(0, 0, 5);
			bad_burst($urandom_range(1, 30));
		end
	endtask

	// closing stretch at full rate on both sides
	task automatic test_steady_tail();
		quiet = 1'b1;
		repeat (100) random_sample(5, 5, 5);
	endtask

	initial begin
		in_valid = 1'b0;
		read_ok = 1'b0;
		enc_angle = '0;
		hall_event = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_gate_edges();
		test_hall_and_step_extremes();
		test_threshold_corners();
		test_tracking_walk();
		test_streaks_and_recovery();
		test_steady_tail();

		// drain and let the pipeline run dry
		settle();
		repeat (8) @(negedge clk);

		$display("covered %0d samples, %0d results checked, %0d gated in, %0d recovery pulses",
			items_sent, results_checked, used_seen, pulses_seen);
		$display("%0d register writes: zero thresholds, offset and step extremes, masked writes",
			reg_writes);
		if (errors == 0 && pending_readouts.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
